// ===== hdl/lru_cache_tags_with_process_quota_assert.svh =====
// assertion macros for the lru cache tag engine
`ifndef LRU_CACHE_TAGS_WITH_PROCESS_QUOTA_ASSERT_SVH
`define LRU_CACHE_TAGS_WITH_PROCESS_QUOTA_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LCQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcq assertion failed");

// next-cycle implication, checked out of reset
`define LCQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcq assertion failed");

`endif

// ===== hdl/lcq_pkg.sv =====
// shared types and constants of the lru cache tag engine
`timescale 1ns / 1ps
package lcq_pkg;

  localparam int unsigned LCQ_ENTRIES = 16;
  localparam int unsigned PROC_W      = 16;
  localparam int unsigned PAGE_W      = 16;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned LIMIT_W     = 5;
  localparam int unsigned OUT_IDX_W   = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd4;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_FILL  = 2'd1,
    CMD_INVAL = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR,
    ST_COMMIT
  } state_t;

  // request and update broadcast to every cell
  typedef struct packed {
    logic              clr_all;
    logic              clr_proc;
    logic              wr_entry;
    logic              wr_stamp;
    logic [PROC_W-1:0] proc;
    logic [PAGE_W-1:0] page;
    logic [STAMP_W-1:0] stamp;
  } lcq_bcast_t;

  // running scan result handed from cell to cell
  typedef struct packed {
    logic               match_found;
    logic               own_found;
    logic [STAMP_W-1:0] glob_stamp;
    logic [STAMP_W-1:0] own_stamp;
  } lcq_acc_t;

endpackage

// ===== hdl/lru_cache_tags_with_process_quota.sv =====
// read and fill: busy through the SCAN and COMMIT states; out_valid is registered from COMMIT
// invalidate and flush: busy in the CLEAR state; out_valid is registered from CLEAR
// one command at a time; the scan walks the chain of ENTRIES cells, one cell a cycle
// results appear for one cycle on out_valid and cannot be held off
// synchronous active-low reset empties every entry, zeroes the stamp, limit back to 4
`timescale 1ns / 1ps
module lru_cache_tags_with_process_quota import lcq_pkg::*; #(
  parameter int unsigned ENTRIES = LCQ_ENTRIES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic [PROC_W-1:0]    in_process_id,
  input  logic [PAGE_W-1:0]    in_page_number,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [OUT_IDX_W-1:0] out_entry_index,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [LIMIT_W-1:0]   cfg_per_process_limit
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  `include "lru_cache_tags_with_process_quota_assert.svh"

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic [LIMIT_W-1:0] limit_r;
  cmd_t               req_cmd_r;
  logic [PROC_W-1:0]  req_proc_r;
  logic [PAGE_W-1:0]  req_page_r;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [OUT_IDX_W-1:0] out_idx_r;

  lcq_bcast_t       bcast;
  logic [IDX_W-1:0] wr_idx;
  logic             res_valid;
  logic             res_hit;
  logic [IDX_W-1:0] res_idx;
  logic             at_quota;

  lcq_acc_t         acc      [ENTRIES+1];
  logic [IDX_W-1:0] match_idx[ENTRIES+1];
  logic [IDX_W-1:0] glob_idx [ENTRIES+1];
  logic [IDX_W-1:0] own_idx  [ENTRIES+1];
  logic [CNT_W-1:0] count    [ENTRIES+1];

  assign acc[0]       = '0;
  assign match_idx[0] = '0;
  assign glob_idx[0]  = '0;
  assign own_idx[0]   = '0;
  assign count[0]     = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lcq_cell #(
      .ENTRIES  (ENTRIES),
      .CELL_IDX (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .bcast       (bcast),
      .wr_idx      (wr_idx),
      .acc_i       (acc[i]),
      .match_idx_i (match_idx[i]),
      .glob_idx_i  (glob_idx[i]),
      .own_idx_i   (own_idx[i]),
      .count_i     (count[i]),
      .acc_o       (acc[i+1]),
      .match_idx_o (match_idx[i+1]),
      .glob_idx_o  (glob_idx[i+1]),
      .own_idx_o   (own_idx[i+1]),
      .count_o     (count[i+1])
    );
  end

  // a process holding no entries always takes the global victim
  assign at_quota = (count[ENTRIES] != '0) &&
                    (CMP_W'(count[ENTRIES]) >= CMP_W'(limit_r));

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    stamp_nxt      = stamp_r;
    bcast          = '0;
    bcast.proc     = req_proc_r;
    bcast.page     = req_page_r;
    bcast.stamp    = stamp_r + STAMP_W'(1);
    wr_idx         = '0;
    res_valid      = 1'b0;
    res_hit        = 1'b0;
    res_idx        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          if (in_command == CMD_INVAL || in_command == CMD_FLUSH) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_CLEAR: begin
        bcast.clr_all  = (req_cmd_r == CMD_FLUSH);
        bcast.clr_proc = (req_cmd_r == CMD_INVAL);
        res_valid      = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        res_valid = 1'b1;
        state_nxt = ST_IDLE;
        if (req_cmd_r == CMD_FILL) begin
          bcast.wr_entry = 1'b1;
          stamp_nxt      = bcast.stamp;
          res_hit        = acc[ENTRIES].match_found;
          if (acc[ENTRIES].match_found) begin
            wr_idx = match_idx[ENTRIES];
          end else if (at_quota) begin
            wr_idx = own_idx[ENTRIES];
          end else begin
            wr_idx = glob_idx[ENTRIES];
          end
          res_idx = wr_idx;
        end else if (acc[ENTRIES].match_found) begin
          bcast.wr_stamp = 1'b1;
          stamp_nxt      = bcast.stamp;
          wr_idx         = match_idx[ENTRIES];
          res_hit        = 1'b1;
          res_idx        = match_idx[ENTRIES];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      stamp_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      stamp_r     <= stamp_nxt;
      out_valid_r <= res_valid;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_per_process_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      req_cmd_r  <= cmd_t'(in_command);
      req_proc_r <= in_process_id;
      req_page_r <= in_page_number;
    end
    if (res_valid) begin
      out_hit_r <= res_hit;
      out_idx_r <= OUT_IDX_W'(res_idx);
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_entry_index = out_idx_r;

  `LCQ_ASSERT_NOW(a_strobe_when_idle, out_valid_r, state_r == ST_IDLE)
  `LCQ_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy)
  `LCQ_ASSERT_NEXT(a_stamp_only_on_commit, state_r != ST_COMMIT, $stable(stamp_r))
  `LCQ_ASSERT_NOW(a_single_update, bcast.wr_entry || bcast.wr_stamp,
                  !bcast.clr_all && !bcast.clr_proc && !(bcast.wr_entry && bcast.wr_stamp))

endmodule

// ===== hdl/lcq_cell.sv =====
// one cache entry plus its stage of the scan chain
`timescale 1ns / 1ps
module lcq_cell import lcq_pkg::*; #(
  parameter int unsigned ENTRIES  = LCQ_ENTRIES,
  parameter int unsigned CELL_IDX = 0,
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lcq_bcast_t       bcast,
  input  logic [IDX_W-1:0] wr_idx,
  input  lcq_acc_t         acc_i,
  input  logic [IDX_W-1:0] match_idx_i,
  input  logic [IDX_W-1:0] glob_idx_i,
  input  logic [IDX_W-1:0] own_idx_i,
  input  logic [CNT_W-1:0] count_i,
  output lcq_acc_t         acc_o,
  output logic [IDX_W-1:0] match_idx_o,
  output logic [IDX_W-1:0] glob_idx_o,
  output logic [IDX_W-1:0] own_idx_o,
  output logic [CNT_W-1:0] count_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic               valid_r;
  logic [PROC_W-1:0]  proc_r;
  logic [PAGE_W-1:0]  page_r;
  logic [STAMP_W-1:0] stamp_r;

  lcq_acc_t           acc_r, acc_nxt;
  logic [IDX_W-1:0]   match_idx_r, match_idx_nxt;
  logic [IDX_W-1:0]   glob_idx_r, glob_idx_nxt;
  logic [IDX_W-1:0]   own_idx_r, own_idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic own_proc;
  logic page_hit;
  logic sel_me;

  assign own_proc = valid_r && (proc_r == bcast.proc);
  assign page_hit = own_proc && (page_r == bcast.page);
  assign sel_me   = (wr_idx == MY_IDX);

  always_comb begin
    acc_nxt       = acc_i;
    match_idx_nxt = match_idx_i;
    glob_idx_nxt  = glob_idx_i;
    own_idx_nxt   = own_idx_i;
    count_nxt     = count_i + CNT_W'(own_proc);
    if (!acc_i.match_found && page_hit) begin
      acc_nxt.match_found = 1'b1;
      match_idx_nxt       = MY_IDX;
    end
    // entry 0 seeds the global minimum; later ones must be strictly lower
    if (CELL_IDX == 0 || stamp_r < acc_i.glob_stamp) begin
      acc_nxt.glob_stamp = stamp_r;
      glob_idx_nxt       = MY_IDX;
    end
    if (own_proc && (!acc_i.own_found || stamp_r < acc_i.own_stamp)) begin
      acc_nxt.own_found = 1'b1;
      acc_nxt.own_stamp = stamp_r;
      own_idx_nxt       = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    match_idx_r <= match_idx_nxt;
    glob_idx_r  <= glob_idx_nxt;
    own_idx_r   <= own_idx_nxt;
    count_r     <= count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stamp_r <= '0;
    end else if (bcast.clr_all || (bcast.clr_proc && own_proc)) begin
      valid_r <= 1'b0;
      stamp_r <= '0;
    end else if (bcast.wr_entry && sel_me) begin
      valid_r <= 1'b1;
      stamp_r <= bcast.stamp;
    end else if (bcast.wr_stamp && sel_me) begin
      stamp_r <= bcast.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (bcast.wr_entry && sel_me) begin
      proc_r <= bcast.proc;
      page_r <= bcast.page;
    end
  end

  assign acc_o       = acc_r;
  assign match_idx_o = match_idx_r;
  assign glob_idx_o  = glob_idx_r;
  assign own_idx_o   = own_idx_r;
  assign count_o     = count_r;

endmodule
